// File: design/css_pkg.sv
package css_pkg;

  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned DOT_W    = 48;
  localparam int unsigned NORM_W   = 47;
  localparam int unsigned PROD_W   = 32;
  localparam int unsigned SIM_W    = 17;
  localparam int unsigned MAG_W    = 16;

  // One finished vector pair handed from the front to the back.
  typedef struct packed {
    logic [DOT_W-1:0]  dot;
    logic [NORM_W-1:0] norm_a;
    logic [NORM_W-1:0] norm_b;
  } job_t;

endpackage

// File: design/css_front.sv
module css_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [css_pkg::WEIGHT_W-1:0] weight_a_i,
  input  logic signed [css_pkg::WEIGHT_W-1:0] weight_b_i,
  input  logic                                last_element_i,
  output logic                                push_o,
  output css_pkg::job_t                       job_o,
  input  logic                                full_i
);
  import css_pkg::*;

  logic                     s1_valid_q, s1_last_q;
  logic signed [PROD_W-1:0] prod_ab_q;
  logic signed [PROD_W-1:0] sq_a_q, sq_b_q;
  logic signed [PROD_W-1:0] prod_ab, sq_a, sq_b;
  logic                     counted, advance, take;
  logic [DOT_W-1:0]         dot_q, dot_d;
  logic [NORM_W-1:0]        norm_a_q, norm_a_d, norm_b_q, norm_b_d;

  assign counted = (weight_a_i != '0) && (weight_b_i != '0);
  assign prod_ab = weight_a_i * weight_b_i;
  assign sq_a    = weight_a_i * weight_a_i;
  assign sq_b    = weight_b_i * weight_b_i;

  // A last beat waits in stage one until the queue has room.
  assign advance    = s1_valid_q && (!s1_last_q || !full_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign take       = in_valid_i && in_ready_o;

  assign dot_d    = dot_q + {{(DOT_W-PROD_W){prod_ab_q[PROD_W-1]}}, prod_ab_q};
  assign norm_a_d = norm_a_q + {{(NORM_W-PROD_W){1'b0}}, sq_a_q};
  assign norm_b_d = norm_b_q + {{(NORM_W-PROD_W){1'b0}}, sq_b_q};

  assign push_o       = advance && s1_last_q;
  assign job_o.dot    = dot_d;
  assign job_o.norm_a = norm_a_d;
  assign job_o.norm_b = norm_b_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
      prod_ab_q  <= '0;
      sq_a_q     <= '0;
      sq_b_q     <= '0;
      dot_q      <= '0;
      norm_a_q   <= '0;
      norm_b_q   <= '0;
    end else begin
      if (advance) begin
        if (s1_last_q) begin
          dot_q    <= '0;
          norm_a_q <= '0;
          norm_b_q <= '0;
        end else begin
          dot_q    <= dot_d;
          norm_a_q <= norm_a_d;
          norm_b_q <= norm_b_d;
        end
      end
      if (take) begin
        s1_valid_q <= 1'b1;
        s1_last_q  <= last_element_i;
        // Drop pairs with a zero element.
        prod_ab_q  <= counted ? prod_ab : '0;
        sq_a_q     <= counted ? sq_a : '0;
        sq_b_q     <= counted ? sq_b : '0;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> (s1_valid_q && $stable(prod_ab_q) && $stable(s1_last_q)))
    else $error("stage one lost a stalled beat");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !full_i)
    else $error("push into a full queue");
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (dot_q == '0 && norm_a_q == '0 && norm_b_q == '0))
    else $error("sums not cleared after last beat");

endmodule

// File: design/css_fifo.sv
module css_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  css_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output css_pkg::job_t data_o,
  output logic          empty_o
);
  import css_pkg::*;

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;

  assign full_o  = count_q == (PtrW+1)'(Depth);
  assign empty_o = count_q == '0;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue underflow");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PtrW+1)'(Depth))
    else $error("queue count out of range");

endmodule

// File: design/css_back.sv
module css_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             empty_i,
  input  css_pkg::job_t                    job_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [css_pkg::SIM_W-1:0] similarity_o
);
  import css_pkg::*;

  localparam int unsigned PW       = 2 * NORM_W;        // sa * sb
  localparam int unsigned MW       = 2 * DOT_W;         // mag^2
  localparam int unsigned RootSh   = 30;                // 2^30 scale of mag^2
  localparam int unsigned WW       = MW + RootSh;       // compare width
  localparam int unsigned MulSteps = DOT_W;
  localparam int unsigned CntW     = $clog2(MulSteps);
  localparam int unsigned KW       = $clog2(MAG_W);
  localparam logic [KW-1:0] TopBit = KW'(MAG_W - 2);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_TOP, S_ADD, S_CMP, S_OUT} state_e;

  state_e             state_q;
  logic               neg_q;
  logic [PW-1:0]      p_acc_q, p_mc_q;
  logic [NORM_W-1:0]  p_mp_q;
  logic [MW-1:0]      m_acc_q, m_mc_q;
  logic [DOT_W-1:0]   m_mp_q;
  logic [CntW-1:0]    cnt_q;
  logic [WW-1:0]      t_q, u_q, cand_q;
  logic [KW-1:0]      k_q;
  logic [MAG_W-1:0]   q_q;
  logic               out_valid_q;
  logic [SIM_W-1:0]   sim_q;

  logic [DOT_W-1:0]   mag;
  logic [WW-1:0]      p_wide, r_wide, cand_d;
  logic [KW:0]        sh_u, sh_p;
  logic [SIM_W-1:0]   q_ext;
  logic               load;

  assign mag    = job_i.dot[DOT_W-1] ? (~job_i.dot + 1'b1) : job_i.dot;
  assign p_wide = {{(WW-PW){1'b0}}, p_acc_q};
  assign r_wide = {m_acc_q, {RootSh{1'b0}}};
  assign sh_u   = {1'b0, k_q} + 1'b1;
  assign sh_p   = {k_q, 1'b0};
  // (q + 2^k)^2 P = q^2 P + 2^(k+1) qP + 2^(2k) P
  assign cand_d = t_q + (u_q << sh_u) + (p_wide << sh_p);
  assign q_ext  = {1'b0, q_q};
  // Load the output register once it is free or being drained.
  assign load   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  assign pop_o        = (state_q == S_IDLE) && !empty_i;
  assign out_valid_o  = out_valid_q;
  assign similarity_o = sim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      neg_q       <= 1'b0;
      p_acc_q     <= '0;
      p_mc_q      <= '0;
      p_mp_q      <= '0;
      m_acc_q     <= '0;
      m_mc_q      <= '0;
      m_mp_q      <= '0;
      cnt_q       <= '0;
      t_q         <= '0;
      u_q         <= '0;
      cand_q      <= '0;
      k_q         <= '0;
      q_q         <= '0;
      out_valid_q <= 1'b0;
      sim_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            neg_q   <= job_i.dot[DOT_W-1];
            q_q     <= '0;
            p_acc_q <= '0;
            p_mc_q  <= {{(PW-NORM_W){1'b0}}, job_i.norm_a};
            p_mp_q  <= job_i.norm_b;
            m_acc_q <= '0;
            m_mc_q  <= {{(MW-DOT_W){1'b0}}, mag};
            m_mp_q  <= mag;
            cnt_q   <= '0;
            state_q <= (job_i.dot == '0) ? S_OUT : S_MUL;
          end
        end
        S_MUL: begin
          if (p_mp_q[0]) begin
            p_acc_q <= p_acc_q + p_mc_q;
          end
          if (m_mp_q[0]) begin
            m_acc_q <= m_acc_q + m_mc_q;
          end
          p_mc_q <= p_mc_q << 1;
          p_mp_q <= p_mp_q >> 1;
          m_mc_q <= m_mc_q << 1;
          m_mp_q <= m_mp_q >> 1;
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q == CntW'(MulSteps - 1)) begin
            state_q <= S_TOP;
          end
        end
        S_TOP: begin
          // Full scale when sa*sb <= mag^2.
          if ({{(MW-PW){1'b0}}, p_acc_q} <= m_acc_q) begin
            q_q     <= MAG_W'(1) << (MAG_W - 1);
            state_q <= S_OUT;
          end else begin
            t_q     <= '0;
            u_q     <= '0;
            k_q     <= TopBit;
            state_q <= S_ADD;
          end
        end
        S_ADD: begin
          cand_q  <= cand_d;
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (cand_q <= r_wide) begin
            t_q <= cand_q;
            u_q <= u_q + (p_wide << k_q);
            q_q <= q_q | (MAG_W'(1) << k_q);
          end
          if (k_q == '0) begin
            state_q <= S_OUT;
          end else begin
            k_q     <= k_q - 1'b1;
            state_q <= S_ADD;
          end
        end
        S_OUT: begin
          if (load) begin
            sim_q   <= neg_q ? (~q_ext + 1'b1) : q_ext;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_sim_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ($signed(sim_q) >= -32768 && $signed(sim_q) <= 32768))
    else $error("similarity out of range");
  a_cmp_after_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> ($past(state_q) == S_ADD))
    else $error("compare without candidate");
  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q != S_IDLE))
    else $error("popped job not started");

endmodule

// File: design/cosine_similarity_stream.sv
// Cosine similarity of two vectors streamed as same-index element pairs in
// signed Q8.8. Pairs where either element is zero are skipped; the norms cover
// only the shared nonzero dimensions. The front end takes one pair per cycle
// (a last pair waits while the queue is full) and accumulates dot and norm
// sums; on the pair marked last it posts the sums to a two-entry queue and
// clears. The back end turns each posted vector into a Q2.15 result
// (truncated, saturated to +/-1.0, 0 when the dot sum is 0): two 48-step serial
// multipliers form sa*sb and dot^2, then a bit-by-bit root search settles the
// magnitude in 15 steps, each an add state and a compare state. A zero dot sum
// skips the multiply and search, a full-scale result skips the search. Short
// vectors keep the front at full rate until the queue fills, after which the
// front waits on the back end.
module cosine_similarity_stream (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [css_pkg::WEIGHT_W-1:0] weight_a_i,
  input  logic signed [css_pkg::WEIGHT_W-1:0] weight_b_i,
  input  logic                                last_element_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [css_pkg::SIM_W-1:0]    similarity_o
);
  import css_pkg::*;

  logic push, full, pop, empty;
  job_t job_in, job_out;

  css_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .weight_a_i     (weight_a_i),
    .weight_b_i     (weight_b_i),
    .last_element_i (last_element_i),
    .push_o         (push),
    .job_o          (job_in),
    .full_i         (full)
  );

  css_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (job_out),
    .empty_o (empty)
  );

  css_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .job_i        (job_out),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .similarity_o (similarity_o)
  );

endmodule

// File: tb/cosine_similarity_stream_tb.sv
module cosine_similarity_stream_tb;
  import css_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned DRAIN_CYCLES = 300;

  class sim_scoreboard;
    logic [DOT_W-1:0]  dot_acc;
    logic [NORM_W-1:0] norm_a_acc;
    logic [NORM_W-1:0] norm_b_acc;
    logic signed [SIM_W-1:0] pending_sims[$];
    int errors;

    function new();
      dot_acc = '0;
      norm_a_acc = '0;
      norm_b_acc = '0;
      errors = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    // largest q in [0, 32768] with q^2 * sa * sb <= mag^2 * 2^30
    function automatic int unsigned cos_mag(logic [DOT_W-1:0] mag,
                                            logic [NORM_W-1:0] sa,
                                            logic [NORM_W-1:0] sb);
      bit [191:0] prod, rhs, lhs, qq, wa, wb, wm;
      int unsigned lo, hi, mid;
      wa = sa;
      wb = sb;
      wm = mag;
      prod = wa * wb;
      rhs = (wm * wm) << 30;
      lo = 0;
      hi = 32768;
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        qq = mid * mid;
        lhs = prod * qq;
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      return lo;
    endfunction

    function void note_beat(logic signed [WEIGHT_W-1:0] a,
                            logic signed [WEIGHT_W-1:0] b, logic last);
      logic signed [PROD_W-1:0] pab;
      logic [PROD_W-1:0] paa, pbb;
      logic [DOT_W-1:0] mag;
      int unsigned q;
      logic signed [SIM_W-1:0] res;
      if (a != 0 && b != 0) begin
        pab = a * b;
        paa = a * a;
        pbb = b * b;
        dot_acc = dot_acc + {{(DOT_W-PROD_W){pab[PROD_W-1]}}, pab};
        norm_a_acc = norm_a_acc + NORM_W'(paa);
        norm_b_acc = norm_b_acc + NORM_W'(pbb);
      end
      if (!last) return;
      res = '0;
      if (dot_acc != 0) begin
        mag = dot_acc[DOT_W-1] ? (~dot_acc + 1'b1) : dot_acc;
        q = cos_mag(mag, norm_a_acc, norm_b_acc);
        res = dot_acc[DOT_W-1] ? -SIM_W'(q) : SIM_W'(q);
      end
      pending_sims.push_back(res);
      dot_acc = '0;
      norm_a_acc = '0;
      norm_b_acc = '0;
    endfunction

    task check(logic signed [SIM_W-1:0] got);
      logic signed [SIM_W-1:0] want;
      if (pending_sims.size() == 0) begin
        report($sformatf("unexpected similarity %0d", got));
        return;
      end
      want = pending_sims.pop_front();
      if (got !== want) report($sformatf("similarity got %0d want %0d", got, want));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [WEIGHT_W-1:0] weight_a_i = '0;
  logic signed [WEIGHT_W-1:0] weight_b_i = '0;
  logic last_element_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [SIM_W-1:0] similarity_o;

  sim_scoreboard sims = new();
  int unsigned cycle_cnt = 0;
  int unsigned burst_left = 0;
  bit gaps_on = 1'b1;
  int unsigned beats_sent = 0;

  always #6 clk_i = ~clk_i;

  cosine_similarity_stream u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .weight_a_i    (weight_a_i),
    .weight_b_i    (weight_b_i),
    .last_element_i(last_element_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .similarity_o  (similarity_o)
  );

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("cosine_similarity_stream_tb failed");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) sims.check(similarity_o);
  end

  // Receiver: stall pattern changes after each run of one random mode; one long hold-off.
  initial begin : receiver
    int unsigned mode;
    int unsigned pattern_cnt;
    pattern_cnt = 0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      repeat (64) begin
        @(negedge clk_i);
        case (mode)
          0: out_ready_i = 1'b1;
          1: out_ready_i = ($urandom_range(0, 1) == 0);
          2: out_ready_i = ($urandom_range(0, 9) == 0);
          default: out_ready_i = (cycle_cnt % 5) != 0;
        endcase
      end
      pattern_cnt++;
      // Hold off long enough for the queue to fill and the input to stall.
      if (pattern_cnt == 40) begin
        repeat (1500) begin
          @(negedge clk_i);
          out_ready_i = 1'b0;
        end
      end
    end
  end

  function automatic logic signed [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 16'sh8000;
      2: return 16'sh7fff;
      3: return ($urandom_range(0, 1) != 0) ? 16'sd1 : -16'sd1;
      default: return WEIGHT_W'($urandom());
    endcase
  endfunction

  task automatic send_beat(logic signed [WEIGHT_W-1:0] a, logic signed [WEIGHT_W-1:0] b,
                           logic last);
    in_valid_i = 1'b1;
    weight_a_i = a;
    weight_b_i = b;
    last_element_i = last;
    do @(posedge clk_i); while (!in_ready_o);
    sims.note_beat(a, b, last);
    beats_sent++;
    @(negedge clk_i);
    if (!gaps_on) return;
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 20);
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i = 1'b0;
        repeat ($urandom_range(1, 8)) begin
          weight_a_i = WEIGHT_W'($urandom());
          weight_b_i = WEIGHT_W'($urandom());
          last_element_i = 1'($urandom_range(0, 1));
          @(negedge clk_i);
        end
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_vector(int unsigned len);
    for (int unsigned i = 0; i < len; i++)
      send_beat(pick_weight(), pick_weight(), i == len - 1);
  endtask

  initial begin : stimulus
    int unsigned len;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_beat(16'sh7fff, 16'sh7fff, 1'b1);
    send_beat(16'sh8000, 16'sh8000, 1'b1);
    send_beat(16'sh8000, 16'sh7fff, 1'b1);
    send_beat(16'sd1, -16'sd1, 1'b1);
    send_beat(16'sd0, 16'sd5, 1'b1);
    send_beat(16'sd5, 16'sd0, 1'b0);
    send_beat(16'sd3, 16'sd4, 1'b1);
    send_beat(16'sd0, 16'sd0, 1'b1);
    send_beat(16'sd1, 16'sd1, 1'b0);
    send_beat(16'sd1, -16'sd1, 1'b1);
    send_beat(16'sd3, 16'sd4, 1'b0);
    send_beat(16'sd4, -16'sd3, 1'b0);
    send_beat(-16'sd7, 16'sd2, 1'b1);
    send_beat(16'sh7fff, 16'sd1, 1'b0);
    send_beat(16'sd1, 16'sh7fff, 1'b1);
    send_beat(16'sh5555, 16'shaaaa, 1'b0);
    send_beat(16'shffff, 16'sh0100, 1'b1);

    while (beats_sent < 730) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      send_vector(len);
    end
    send_vector(3);

    in_valid_i = 1'b0;
    while (sims.pending_sims.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sims.errors == 0) begin
      $display("cosine_similarity_stream_tb passed");
    end else begin
      $display("cosine_similarity_stream_tb failed");
    end
    $finish;
  end

endmodule
